### hdl/mh64_pkg.sv
`timescale 1ns / 1ps

package mh64_pkg;

    localparam int WORD_W    = 64;
    localparam int COUNT_W   = 4;
    localparam int LEN_W     = 32;
    localparam int MIX_SHIFT = 47;

    localparam logic [WORD_W-1:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
    localparam logic [31:0]       MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0]       MIX_MUL_HI = MIX_MUL[63:32];

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // how the back end handles the word of a request
    localparam logic [1:0] KIND_FULL  = 2'd0;
    localparam logic [1:0] KIND_TAIL  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic              first;
        logic              last;
        logic [WORD_W-1:0] word;     // already masked for a tail
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### hdl/mh64_if.sv
`timescale 1ns / 1ps

interface mh64_in_if;
    logic                           valid;
    logic                           ready;
    logic [mh64_pkg::WORD_W-1:0]    data_word;
    logic [mh64_pkg::COUNT_W-1:0]   byte_count;
    logic                           first_word;
    logic                           last_word;
    logic [mh64_pkg::LEN_W-1:0]     message_length;

    modport source (
        output valid, data_word, byte_count, first_word, last_word, message_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_word, last_word, message_length,
        output ready
    );
endinterface

interface mh64_out_if;
    logic                           valid;
    logic                           ready;
    logic [mh64_pkg::WORD_W-1:0]    hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

interface mh64_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mh64_pkg::WORD_W-1:0]    seed_value;

    modport source (output valid, seed_value, input ready);
    modport sink   (input valid, seed_value, output ready);
endinterface

### hdl/mh64_front.sv
`timescale 1ns / 1ps

module mh64_front (
    input  logic                  clk,
    input  logic                  rst_n,
    mh64_in_if.sink               in_ch,
    input  mh64_pkg::q_status_t   q_status,
    output logic                  push,
    output mh64_pkg::cmd_t        push_cmd
);

    logic open_reg;
    logic open_next;
    logic accept;
    logic [mh64_pkg::WORD_W-1:0] tail_word;

    assign in_ch.ready = !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;

    // items outside an open message are taken and dropped
    assign push = accept && (in_ch.first_word || open_reg);

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            tail_word[8*i +: 8] = (in_ch.byte_count > 4'(i)) ? in_ch.data_word[8*i +: 8] : 8'h00;
        end
    end

    always_comb
    begin
        push_cmd.first = in_ch.first_word;
        push_cmd.last  = in_ch.last_word;
        push_cmd.len   = in_ch.message_length;
        if (!in_ch.last_word || (in_ch.byte_count >= 4'd8))
        begin
            push_cmd.kind = mh64_pkg::KIND_FULL;
            push_cmd.word = in_ch.data_word;
        end
        else if (in_ch.byte_count != 4'd0)
        begin
            push_cmd.kind = mh64_pkg::KIND_TAIL;
            push_cmd.word = tail_word;
        end
        else
        begin
            push_cmd.kind = mh64_pkg::KIND_EMPTY;
            push_cmd.word = '0;
        end
    end

    always_comb
    begin
        open_next = open_reg;
        if (push)
        begin
            open_next = !in_ch.last_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

endmodule

### hdl/mh64_queue.sv
`timescale 1ns / 1ps

module mh64_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mh64_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output mh64_pkg::cmd_t        head_cmd,
    output mh64_pkg::q_status_t   status
);

    mh64_pkg::cmd_t              mem_reg [mh64_pkg::QUEUE_DEPTH];
    logic [mh64_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [mh64_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [mh64_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [mh64_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [mh64_pkg::QCNT_W-1:0] count_reg;
    logic [mh64_pkg::QCNT_W-1:0] count_next;

    assign status.full  = (count_reg == mh64_pkg::QCNT_W'(mh64_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue read while empty");

endmodule

### hdl/mh64_mul.sv
`timescale 1ns / 1ps

// x * MIX_MUL mod 2^64 over three 32x32 partial products, one per cycle
module mh64_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mh64_pkg::mul_req_t    req,
    output mh64_pkg::mul_rsp_t    rsp
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [1:0]                  step_reg;
    logic [1:0]                  step_next;
    logic                        done_reg;
    logic                        done_next;
    logic [mh64_pkg::WORD_W-1:0] a_reg;
    logic [mh64_pkg::WORD_W-1:0] acc_reg;
    logic [31:0]                 mult_a;
    logic [31:0]                 mult_b;
    logic [63:0]                 pp;
    logic                        take;

    assign take   = req.start && !busy_reg;
    assign mult_a = (step_reg == 2'd1) ? a_reg[63:32] : a_reg[31:0];
    assign mult_b = (step_reg == 2'd2) ? mh64_pkg::MIX_MUL_HI : mh64_pkg::MIX_MUL_LO;
    assign pp     = mult_a * mult_b;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (take)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_reg <= req.operand;
        end
        if (busy_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_reg <= pp;
            end
            else
            begin
                // cross terms only reach the upper half
                acc_reg[63:32] <= acc_reg[63:32] + pp[31:0];
            end
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

    a_done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && ($past(step_reg) == 2'd2)))
        else $error("product flagged without a full pass");

endmodule

### hdl/mh64_back.sv
`timescale 1ns / 1ps

module mh64_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mh64_pkg::WORD_W-1:0] seed,
    input  mh64_pkg::q_status_t         q_status,
    input  mh64_pkg::cmd_t              head_cmd,
    output logic                        pop,
    output mh64_pkg::mul_req_t          mul_req,
    input  mh64_pkg::mul_rsp_t          mul_rsp,
    mh64_out_if.source                  out_ch
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LEN  = 4'd1;
    localparam logic [3:0] S_BODY = 4'd2;
    localparam logic [3:0] S_K1   = 4'd3;
    localparam logic [3:0] S_K2   = 4'd4;
    localparam logic [3:0] S_H    = 4'd5;
    localparam logic [3:0] S_FIN0 = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0]                  state_reg;
    logic [3:0]                  state_next;
    mh64_pkg::cmd_t              cmd_reg;
    mh64_pkg::cmd_t              cmd_next;
    logic [mh64_pkg::WORD_W-1:0] h_reg;
    logic [mh64_pkg::WORD_W-1:0] h_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [mh64_pkg::WORD_W-1:0] out_hash_reg;
    logic [mh64_pkg::WORD_W-1:0] out_hash_next;
    logic [mh64_pkg::WORD_W-1:0] prod;
    logic [mh64_pkg::WORD_W-1:0] prod_sx;

    assign prod    = mul_rsp.product;
    assign prod_sx = prod ^ (prod >> mh64_pkg::MIX_SHIFT);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        h_next          = h_reg;
        pop             = 1'b0;
        mul_req.start   = 1'b0;
        mul_req.operand = '0;
        out_valid_next  = out_valid_reg;
        out_hash_next   = out_hash_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    if (head_cmd.first)
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = {{(mh64_pkg::WORD_W-mh64_pkg::LEN_W){1'b0}},
                                           head_cmd.len};
                        state_next      = S_LEN;
                    end
                    else
                    begin
                        state_next = S_BODY;
                    end
                end
            end
            S_LEN:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = seed ^ prod;
                    state_next = S_BODY;
                end
            end
            S_BODY:
            begin
                case (cmd_reg.kind)
                    mh64_pkg::KIND_FULL:
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = cmd_reg.word;
                        state_next      = S_K1;
                    end
                    mh64_pkg::KIND_TAIL:
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = h_reg ^ cmd_reg.word;
                        state_next      = S_H;
                    end
                    default:
                    begin
                        state_next = cmd_reg.last ? S_FIN0 : S_IDLE;
                    end
                endcase
            end
            S_K1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = prod_sx;
                    state_next      = S_K2;
                end
            end
            S_K2:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = h_reg ^ prod;
                    state_next      = S_H;
                end
            end
            S_H:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = prod;
                    state_next = cmd_reg.last ? S_FIN0 : S_IDLE;
                end
            end
            S_FIN0:
            begin
                mul_req.start   = 1'b1;
                mul_req.operand = h_reg ^ (h_reg >> mh64_pkg::MIX_SHIFT);
                state_next      = S_FIN;
            end
            S_FIN:
            begin
                if (mul_rsp.done)
                begin
                    h_next     = prod_sx;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = h_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            h_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_hash_reg <= out_hash_next;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.hash_value = out_hash_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == S_IDLE))
        else $error("request taken mid-sequence");

endmodule

### hdl/murmur2_hash64_core.sv
`timescale 1ns / 1ps

// 64-bit MurmurHash64A engine.
// in_ch carries message words (little endian, first byte in bits 7:0). Mark the first
// word with first_word and give message_length there; mark the final word with
// last_word and its byte_count (0 to 8). Words that arrive outside an open message
// are taken and dropped; a new first word abandons an open message.
// out_ch carries one hash_value per message, after its last word.
// cfg writes seed_value (always ready); write it only while no message is in flight.
// All multiplies by the mixing constant share one 32x32 multiplier, which builds
// each 64-bit product from partial products. A full word costs three products; a
// tail word one; the first word adds the length product and the last word one
// product for finalization.
// A two-entry queue lets the front take up to two more words while the back works.
// Reset clears the seed to 0, closes any open message and empties the queue.
// When out_ch stalls, the finished hash waits in the output register; the back end
// holds one more finished hash internally and then stops taking words, and in_ch
// drops ready once the queue fills.
module murmur2_hash64_core (
    input  logic       clk,
    input  logic       rst_n,
    mh64_in_if.sink    in_ch,
    mh64_out_if.source out_ch,
    mh64_cfg_if.sink   cfg
);

    logic [mh64_pkg::WORD_W-1:0] seed_reg;
    logic [mh64_pkg::WORD_W-1:0] seed_next;
    logic                        push;
    logic                        pop;
    mh64_pkg::cmd_t              push_cmd;
    mh64_pkg::cmd_t              head_cmd;
    mh64_pkg::q_status_t         q_status;
    mh64_pkg::mul_req_t          mul_req;
    mh64_pkg::mul_rsp_t          mul_rsp;

    assign cfg.ready = 1'b1;
    assign seed_next = (cfg.valid && cfg.ready) ? cfg.seed_value : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    mh64_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mh64_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    mh64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    mh64_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed     (seed_reg),
        .q_status (q_status),
        .head_cmd (head_cmd),
        .pop      (pop),
        .mul_req  (mul_req),
        .mul_rsp  (mul_rsp),
        .out_ch   (out_ch)
    );

endmodule

### tb/murmur2_hash64_core_check.sv
`timescale 1ns / 1ps

module murmur2_hash64_core_check (
    input  logic clk,
    input  logic rst_n,
    mh64_in_if   in_mon,
    mh64_out_if  out_mon,
    mh64_cfg_if  cfg_mon,
    output int   mismatch_count,
    output int   pending
);
    import mh64_pkg::*;

    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] chain_hash;
    logic              msg_open;
    logic [WORD_W-1:0] next_hash;
    logic [WORD_W-1:0] want;
    logic [WORD_W-1:0] expected_hashes [$];
    int                errors = 0;

    function automatic logic [WORD_W-1:0] premix_word(input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] t;
        t = k * MIX_MUL;
        t = t ^ (t >> MIX_SHIFT);
        t = t * MIX_MUL;
        return t;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   = '0;
            chain_hash = '0;
            msg_open   = 1'b0;
            expected_hashes.delete();
        end
        else
        begin
            // retire first: a hash never leaves in the cycle its request is taken
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: hash %h with no request outstanding",
                                 $realtime, out_mon.hash_value);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (out_mon.hash_value !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: hash_value expected %h, got %h",
                                     $realtime, want, out_mon.hash_value);
                    end
                end
            end

            if (cfg_mon.valid && cfg_mon.ready)
                seed_reg = cfg_mon.seed_value;

            // words with no open message and no first mark are dropped
            if (in_mon.valid && in_mon.ready && (in_mon.first_word || msg_open))
            begin
                if (in_mon.first_word)
                begin
                    chain_hash = seed_reg ^
                        ({{(WORD_W-LEN_W){1'b0}}, in_mon.message_length} * MIX_MUL);
                    msg_open = 1'b1;
                end
                next_hash = chain_hash;
                if (!in_mon.last_word || in_mon.byte_count >= 8)
                begin
                    next_hash = next_hash ^ premix_word(in_mon.data_word);
                    next_hash = next_hash * MIX_MUL;
                end
                else if (in_mon.byte_count != 0)
                begin
                    next_hash = next_hash ^ (in_mon.data_word &
                        ((64'd1 << (8 * in_mon.byte_count)) - 64'd1));
                    next_hash = next_hash * MIX_MUL;
                end
                if (in_mon.last_word)
                begin
                    next_hash = next_hash ^ (next_hash >> MIX_SHIFT);
                    next_hash = next_hash * MIX_MUL;
                    next_hash = next_hash ^ (next_hash >> MIX_SHIFT);
                    msg_open  = 1'b0;
                    expected_hashes.push_back(next_hash);
                end
                chain_hash = next_hash;
            end
        end
        mismatch_count <= errors;
        pending        <= expected_hashes.size();
    end

endmodule

### tb/murmur2_hash64_core_tb.sv
`timescale 1ns / 1ps

module murmur2_hash64_core_tb;
    import mh64_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int ITEMS_PER_PHASE = 320;
    localparam int PHASES          = 6;

    logic clk = 1'b0;
    logic rst_n;

    mh64_in_if  in_ch();
    mh64_out_if out_ch();
    mh64_cfg_if cfg_ch();

    int mismatch_count;
    int pending;
    int cycle_count = 0;
    int words_sent;
    int gap_pct = 0;
    int stall_pct = 0;

    murmur2_hash64_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    murmur2_hash64_core_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .cfg_mon        (cfg_ch),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[murmur2_hash64_core] ERROR");
            $finish;
        end
    end

    // hash receiver with stall bursts
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic write_seed(input logic [WORD_W-1:0] value);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.seed_value <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_word(input logic [WORD_W-1:0]  word,
                             input logic [COUNT_W-1:0] count,
                             input logic               first,
                             input logic               last,
                             input logic [LEN_W-1:0]   len,
                             input bit                 counted);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_word      <= word;
        in_ch.byte_count     <= count;
        in_ch.first_word     <= first;
        in_ch.last_word      <= last;
        in_ch.message_length <= len;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (counted)
            words_sent++;
    endtask

    // hold the sender until every hash is out, then let dropped words settle
    task automatic drain_hashes();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_message();
        int               n_bytes;
        int               n_items;
        int               n_send;
        int               i;
        bit               zero_tail;
        bit               abandon;
        logic             last;
        logic [COUNT_W-1:0] count;
        logic [LEN_W-1:0] len;
        n_bytes   = ($urandom_range(0, 15) == 0) ? $urandom_range(41, 160)
                                                 : $urandom_range(0, 40);
        n_items   = (n_bytes + 7) / 8;
        zero_tail = (n_bytes % 8 == 0) && ($urandom_range(0, 3) == 0);
        if (n_items == 0 || zero_tail)
            n_items++;
        len     = ($urandom_range(0, 9) == 0) ? $urandom : n_bytes;
        abandon = ($urandom_range(0, 11) == 0);
        n_send  = abandon ? $urandom_range(1, (n_items > 1) ? n_items - 1 : 1) : n_items;
        for (i = 0; i < n_send; i++)
        begin
            last = !abandon && (i == n_items - 1);
            if (!last)
                count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 15)) : 4'd8;
            else if (n_bytes % 8 != 0)
                count = COUNT_W'(n_bytes % 8);
            else if (zero_tail || n_bytes == 0)
                count = 4'd0;
            else
                count = ($urandom_range(0, 7) == 0) ? COUNT_W'($urandom_range(8, 15)) : 4'd8;
            send_word(rand64(), count, i == 0, last, len, 1'b1);
        end
    endtask

    initial
    begin
        int               phase;
        int               n_msg;
        logic [WORD_W-1:0] seed;

        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.data_word      <= '0;
        in_ch.byte_count     <= '0;
        in_ch.first_word     <= 1'b0;
        in_ch.last_word      <= 1'b0;
        in_ch.message_length <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.seed_value    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        words_sent = 0;

        write_seed({WORD_W{1'b1}});
        // stray words while idle
        send_word(rand64(), 4'd8, 1'b0, 1'b1, 32'd0, 1'b0);
        send_word(rand64(), 4'd8, 1'b0, 1'b0, 32'd0, 1'b0);
        // empty message, data ignored
        send_word(rand64(), 4'd0, 1'b1, 1'b1, 32'd0, 1'b1);
        send_word({WORD_W{1'b1}}, 4'd8, 1'b1, 1'b1, 32'd8, 1'b1);
        send_word('0, 4'd15, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send_word({WORD_W{1'b1}}, 4'd1, 1'b1, 1'b1, 32'd1, 1'b1);
        send_word({WORD_W{1'b1}}, 4'd7, 1'b1, 1'b1, 32'd7, 1'b1);
        // short count on a word that is not last
        send_word(rand64(), 4'd2, 1'b1, 1'b0, 32'd13, 1'b1);
        send_word(rand64(), 4'd5, 1'b0, 1'b1, 32'd13, 1'b1);
        // new first word abandons the open message
        send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd24, 1'b1);
        send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd16, 1'b1);
        send_word(rand64(), 4'd8, 1'b0, 1'b1, 32'd16, 1'b1);
        send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd12, 1'b1);
        send_word({WORD_W{1'b1}}, 4'd4, 1'b0, 1'b1, 32'd12, 1'b1);
        // full words then an empty remainder
        send_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd16, 1'b1);
        send_word(rand64(), 4'd8, 1'b0, 1'b0, 32'd16, 1'b1);
        send_word(rand64(), 4'd0, 1'b0, 1'b1, 32'd16, 1'b1);
        drain_hashes();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       seed = '0;
                1:       seed = 64'd1;
                2:       seed = 64'h8000_0000_0000_0000;
                5:       seed = {WORD_W{1'b1}};
                default: seed = rand64();
            endcase
            write_seed(seed);
            words_sent = 0;
            n_msg      = 0;
            while (words_sent < ITEMS_PER_PHASE)
            begin
                if (n_msg % 30 == 0)
                begin
                    if (phase == PHASES - 1)
                    begin
                        gap_pct   = 0;
                        stall_pct = 0;
                    end
                    else
                    begin
                        case ($urandom_range(0, 2))
                            0:       gap_pct = 0;
                            1:       gap_pct = 10;
                            default: gap_pct = 40;
                        endcase
                        case ($urandom_range(0, 2))
                            0:       stall_pct = 0;
                            1:       stall_pct = 10;
                            default: stall_pct = 40;
                        endcase
                    end
                end
                if ($urandom_range(0, 15) == 0)
                    send_word(rand64(), COUNT_W'($urandom_range(0, 15)), 1'b0,
                              1'($urandom_range(0, 1)), $urandom, 1'b0);
                send_random_message();
                n_msg++;
                if ($urandom_range(0, 39) == 0)
                    drain_hashes();
            end
            drain_hashes();
        end

        if (mismatch_count == 0 && pending == 0)
            $display("[murmur2_hash64_core] OK");
        else
            $display("[murmur2_hash64_core] ERROR");
        $finish;
    end

endmodule
